/* sv/cdc_pkg.sv */
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types, field widths and fixed-point helpers of the conditional
// distance covariance block.
// ----------------------------------------------------------------------------
package cdc_pkg;

    localparam int FUNC_W = 2;
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 16;
    localparam int COV_W  = 48;
    localparam int ACC_W  = 64;
    localparam int CNT_W  = 5;

    // item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_X  = 2'd0,
        FUNC_LOAD_Y  = 2'd1,
        FUNC_LOAD_W  = 2'd2,
        FUNC_START   = 2'd3
    } t_func;

    // weight product, rounded half up to Q4.12 and saturated
    function automatic logic [VAL_W-1:0] wmul(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
        logic [32:0] p;
        logic [20:0] s;
        p = 33'(a) * 33'(b) + 33'd2048;
        s = p[32:12];
        return (s[20:16] != 5'd0) ? 16'hFFFF : s[15:0];
    endfunction

endpackage

/* sv/cdc_in_if.sv */
// ----------------------------------------------------------------------------
// cdc_in_if
// Input item channel: load and start items.
// ----------------------------------------------------------------------------
interface cdc_in_if;
    import cdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output func, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input func, input row, input col, input value,
                    output ready);
endinterface

/* sv/cdc_out_if.sv */
// ----------------------------------------------------------------------------
// cdc_out_if
// Result channel: one covariance value per conditioning point.
// ----------------------------------------------------------------------------
interface cdc_out_if;
    import cdc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        point_index;
    logic signed [COV_W-1:0] covariance;
    logic                    last;

    modport source (output valid, output point_index, output covariance, output last,
                    input ready);
    modport sink   (input valid, input point_index, input covariance, input last,
                    output ready);
endinterface

/* sv/cdc_ram.sv */
// ----------------------------------------------------------------------------
// cdc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* sv/cdc_div.sv */
// ----------------------------------------------------------------------------
// cdc_div
// Restoring divider, one quotient bit per cycle: 64-bit magnitude by a
// 17-bit divisor, done pulse after 64 steps.
// ----------------------------------------------------------------------------
module cdc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [16:0] r_rem;
    logic [16:0] r_d;
    logic [17:0] trial;
    logic [17:0] diff;
    logic        ge;

    // trial subtract of one step
    always_comb begin
        trial = {r_rem, r_q[63]};
        diff  = trial - {1'b0, r_d};
        ge    = trial >= {1'b0, r_d};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], ge};
            r_rem <= ge ? diff[16:0] : trial[16:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

/* sv/conditional_distance_covariance.sv */
// ----------------------------------------------------------------------------
// conditional_distance_covariance
// Brute-force conditional distance covariance over stored distance and
// kernel weight matrices.
// ----------------------------------------------------------------------------
// A load item writes one entry of the x distance, y distance or weight
// store. A start item walks all n^5 terms; the term schedule is set by the
// single read port of each store (seven x/y reads per term) and the
// multiply chain behind it. Each point u then passes through the bit-serial
// divider and the result transfer. Items are taken only while no start
// is running.
module conditional_distance_covariance #(
    parameter int MAX_POINTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [cdc_pkg::CNT_W-1:0] i_cfg_data,
    cdc_in_if.sink                i_in,
    cdc_out_if.source             o_out
);
    import cdc_pkg::*;

    localparam int AW      = $clog2(MAX_POINTS * MAX_POINTS);
    localparam int NMAX    = (MAX_POINTS < 16) ? MAX_POINTS : 16;
    localparam logic [3:0] PH_LAST = 4'd12;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    function automatic logic [IDX_W-1:0] idx_mod(input logic [IDX_W-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int t = 0; t < 16; t++) begin
            if (v == IDX_W'(t)) r = IDX_W'(t % MAX_POINTS);
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] addr(input logic [IDX_W-1:0] r,
                                           input logic [IDX_W-1:0] c);
        return AW'(int'(r) * MAX_POINTS + int'(c));
    endfunction

    function automatic logic signed [17:0] diff4(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b,
                                                 input logic [VAL_W-1:0] c,
                                                 input logic [VAL_W-1:0] d);
        return signed'({2'b0, a} + {2'b0, b} - {2'b0, c} - {2'b0, d});
    endfunction

    t_state                  r_state;
    logic [3:0]              r_phase;
    logic [IDX_W-1:0]        r_u, r_i, r_j, r_k, r_l, r_nm1;
    logic [CNT_W-1:0]        r_point_count;
    logic [8:0]              r_n2;
    logic [16:0]             r_n4;
    logic [VAL_W-1:0]        r_x [7];
    logic [VAL_W-1:0]        r_y [7];
    logic [VAL_W-1:0]        r_wt [4];
    logic signed [17:0]      r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [VAL_W-1:0]        r_wij, r_wijk, r_wall;
    logic signed [35:0]      r_pa, r_pb, r_pcc;
    logic signed [37:0]      r_d;
    logic signed [54:0]      r_term;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_neg;
    logic                    r_div_go;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_idx;
    logic signed [COV_W-1:0] r_out_cov;
    logic                    r_out_last;

    logic                    in_xfer, out_xfer;
    logic [AW-1:0]           load_addr, rx_addr, rw_addr;
    logic [VAL_W-1:0]        x_rdata, y_rdata, w_rdata;
    logic                    we_x, we_y, we_w;
    logic [CNT_W-1:0]        n_eff;
    logic                    l_last, k_last, j_last, i_last;
    logic [ACC_W-1:0]        acc_mag;
    logic                    div_done;
    logic [63:0]             div_quot;
    logic signed [64:0]      q_s, q_c, q_r;
    logic signed [COV_W-1:0] cov_val;
    logic signed [64:0]      acc_sum;
    logic signed [16:0]      w_s;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // store write decode
    assign load_addr = addr(idx_mod(i_in.row), idx_mod(i_in.col));
    assign we_x = in_xfer && (i_in.func == FUNC_LOAD_X);
    assign we_y = in_xfer && (i_in.func == FUNC_LOAD_Y);
    assign we_w = in_xfer && (i_in.func == FUNC_LOAD_W);

    // read address schedule over one term
    always_comb begin
        case (r_phase)
            4'd0:    rx_addr = addr(r_i, r_j);
            4'd1:    rx_addr = addr(r_k, r_l);
            4'd2:    rx_addr = addr(r_i, r_k);
            4'd3:    rx_addr = addr(r_j, r_l);
            4'd4:    rx_addr = addr(r_i, r_l);
            4'd5:    rx_addr = addr(r_j, r_k);
            default: rx_addr = addr(r_k, r_j);
        endcase
        case (r_phase)
            4'd0:    rw_addr = addr(r_i, r_u);
            4'd1:    rw_addr = addr(r_j, r_u);
            4'd2:    rw_addr = addr(r_k, r_u);
            default: rw_addr = addr(r_l, r_u);
        endcase
    end

    cdc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS * MAX_POINTS)) u_x_ram (
        .i_clk(i_clk), .i_we(we_x), .i_waddr(load_addr), .i_wdata(i_in.value),
        .i_raddr(rx_addr), .o_rdata(x_rdata));
    cdc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS * MAX_POINTS)) u_y_ram (
        .i_clk(i_clk), .i_we(we_y), .i_waddr(load_addr), .i_wdata(i_in.value),
        .i_raddr(rx_addr), .o_rdata(y_rdata));
    cdc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS * MAX_POINTS)) u_w_ram (
        .i_clk(i_clk), .i_we(we_w), .i_waddr(load_addr), .i_wdata(i_in.value),
        .i_raddr(rw_addr), .o_rdata(w_rdata));

    // effective point count and loop ends
    always_comb begin
        if (r_point_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_point_count > CNT_W'(NMAX)) begin
            n_eff = CNT_W'(NMAX);
        end else begin
            n_eff = r_point_count;
        end
        l_last = (r_l == r_nm1);
        k_last = (r_k == r_nm1);
        j_last = (r_j == r_nm1);
        i_last = (r_i == r_nm1);
    end

    // saturating accumulate
    assign acc_sum = {r_acc[ACC_W-1], r_acc} + 65'(r_term);
    assign acc_mag = r_acc[ACC_W-1] ? (~r_acc + 64'd1) : r_acc;
    assign w_s     = signed'({1'b0, r_wall});

    cdc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_dividend(acc_mag), .i_divisor(r_n4),
        .o_done(div_done), .o_quotient(div_quot));

    // quotient to Q32.16: clamp, round half up, saturate
    always_comb begin
        q_s = r_neg ? -signed'({1'b0, div_quot}) : signed'({1'b0, div_quot});
        if (q_s > (65'sd1 <<< 60)) begin
            q_c = 65'sd1 <<< 60;
        end else if (q_s < -(65'sd1 <<< 60)) begin
            q_c = -(65'sd1 <<< 60);
        end else begin
            q_c = q_s;
        end
        q_r = (q_c + 65'sd2048) >>> 12;
        if (q_r > 65'sd140737488355327) begin
            cov_val = {1'b0, {(COV_W-1){1'b1}}};
        end else if (q_r < -65'sd140737488355328) begin
            cov_val = {1'b1, {(COV_W-1){1'b0}}};
        end else begin
            cov_val = q_r[COV_W-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= '0;
            r_point_count <= CNT_W'(16);
            r_div_go      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_u <= '0; r_i <= '0; r_j <= '0; r_k <= '0; r_l <= '0;
            r_acc         <= '0;
        end else begin
            r_div_go <= 1'b0;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_in.func == FUNC_START)) begin
                        r_state <= S_RUN;
                        r_phase <= '0;
                        r_u <= '0; r_i <= '0; r_j <= '0; r_k <= '0; r_l <= '0;
                        r_acc <= '0;
                    end
                end
                S_RUN: begin
                    if (r_phase == PH_LAST) begin
                        r_phase <= '0;
                        if (acc_sum[64] != acc_sum[63]) begin
                            r_acc <= acc_sum[64] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                 : {1'b0, {(ACC_W-1){1'b1}}};
                        end else begin
                            r_acc <= acc_sum[ACC_W-1:0];
                        end
                        if (!l_last) begin
                            r_l <= r_l + 4'd1;
                        end else begin
                            r_l <= '0;
                            if (!k_last) begin
                                r_k <= r_k + 4'd1;
                            end else begin
                                r_k <= '0;
                                if (!j_last) begin
                                    r_j <= r_j + 4'd1;
                                end else begin
                                    r_j <= '0;
                                    if (!i_last) begin
                                        r_i <= r_i + 4'd1;
                                    end else begin
                                        r_i      <= '0;
                                        r_state  <= S_DIV;
                                        r_div_go <= 1'b1;
                                    end
                                end
                            end
                        end
                    end else begin
                        r_phase <= r_phase + 4'd1;
                    end
                end
                S_DIV: begin
                    if (div_done && !r_div_go) begin
                        r_state     <= S_OUT;
                        r_out_valid <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_xfer) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RUN;
                            r_u     <= r_u + 4'd1;
                            r_phase <= '0;
                            r_acc   <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // term datapath and result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_in.func == FUNC_START)) begin
            r_nm1 <= IDX_W'(n_eff - CNT_W'(1));
            r_n2  <= 9'(n_eff) * 9'(n_eff);
        end
        r_n4 <= 17'(r_n2) * 17'(r_n2);
        if (r_div_go) begin
            r_neg <= r_acc[ACC_W-1];
        end
        if (r_state == S_RUN) begin
            // capture read data in the phase after its address
            if (r_phase >= 4'd1 && r_phase <= 4'd7) begin
                r_x[3'(r_phase - 4'd1)] <= x_rdata;
                r_y[3'(r_phase - 4'd1)] <= y_rdata;
            end
            if (r_phase >= 4'd1 && r_phase <= 4'd4) begin
                r_wt[2'(r_phase - 4'd1)] <= w_rdata;
            end
            // cross terms and first weight product
            if (r_phase == 4'd8) begin
                r_ax  <= diff4(r_x[0], r_x[1], r_x[2], r_x[3]);
                r_ay  <= diff4(r_y[0], r_y[1], r_y[2], r_y[3]);
                r_bx  <= diff4(r_x[0], r_x[1], r_x[4], r_x[5]);
                r_by  <= diff4(r_y[0], r_y[1], r_y[4], r_y[5]);
                r_cx  <= diff4(r_x[4], r_x[6], r_x[2], r_x[3]);
                r_cy  <= diff4(r_y[4], r_y[6], r_y[2], r_y[3]);
                r_wij <= wmul(r_wt[0], r_wt[1]);
            end
            // cross products and second weight product
            if (r_phase == 4'd9) begin
                r_pa   <= 36'(r_ax) * 36'(r_ay);
                r_pb   <= 36'(r_bx) * 36'(r_by);
                r_pcc  <= 36'(r_cx) * 36'(r_cy);
                r_wijk <= wmul(r_wij, r_wt[2]);
            end
            if (r_phase == 4'd10) begin
                r_d    <= 38'(r_pa) + 38'(r_pb) + 38'(r_pcc);
                r_wall <= wmul(r_wijk, r_wt[3]);
            end
            if (r_phase == 4'd11) begin
                r_term <= 55'(r_d) * 55'(w_s);
            end
        end
        if (r_state == S_DIV && div_done && !r_div_go) begin
            r_out_idx  <= r_u;
            r_out_cov  <= cov_val;
            r_out_last <= (r_u == r_nm1);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.point_index = r_out_idx;
    assign o_out.covariance  = r_out_cov;
    assign o_out.last        = r_out_last;
endmodule
